[src/dpsm_pkg.sv]
// Package with drive state, transition codes and controlword decoding for the drive state machine.
`timescale 1ns / 1ps

package dpsm_pkg;

    localparam int CW_W    = 16;
    localparam int LINK_W  = 8;
    localparam int STATE_W = 3;
    localparam int TRANS_W = 5;
    localparam int SW_W    = 16;

    localparam logic [LINK_W-1:0] LINK_OP_RESET = 8'h08;

    typedef enum logic [STATE_W-1:0] {
        ST_NOT_READY   = 3'd0,
        ST_DISABLED    = 3'd1,
        ST_READY       = 3'd2,
        ST_SWITCHED_ON = 3'd3,
        ST_ENABLED     = 3'd4,
        ST_QUICK_STOP  = 3'd5,
        ST_FAULT_REACT = 3'd6,
        ST_FAULT       = 3'd7
    } t_drive_state;

    typedef enum logic [TRANS_W-1:0] {
        TR_NONE            = 5'd0,
        TR_NRDY_TO_DIS     = 5'd1,
        TR_DIS_TO_RDY      = 5'd2,
        TR_RDY_TO_SON      = 5'd3,
        TR_SON_TO_ENA      = 5'd4,
        TR_ENA_TO_SON      = 5'd5,
        TR_SON_TO_RDY      = 5'd6,
        TR_RDY_TO_DIS      = 5'd7,
        TR_ENA_TO_RDY      = 5'd8,
        TR_ENA_TO_DIS      = 5'd9,
        TR_SON_TO_DIS      = 5'd10,
        TR_ENA_TO_QSTOP    = 5'd11,
        TR_QSTOP_TO_DIS    = 5'd12,
        TR_FREACT_TO_FAULT = 5'd13,
        TR_FAULT_TO_DIS    = 5'd14,
        TR_QSTOP_TO_ENA    = 5'd15,
        TR_RDY_TO_ENA      = 5'd16
    } t_trans;

    typedef struct packed {
        logic [SW_W-1:0] status_word;
        t_drive_state    drive_state;
        t_trans          transition_code;
    } t_step_result;

    // Command masks and values applied to the low byte of the controlword.
    localparam logic [7:0] M_SHUTDOWN = 8'h87, V_SHUTDOWN = 8'h06;
    localparam logic [7:0] M_SWITCH_ON = 8'h87, V_SWITCH_ON = 8'h07;
    localparam logic [7:0] M_ENABLE = 8'h8F, V_ENABLE = 8'h0F;
    localparam logic [7:0] M_DIS_VOLT = 8'h82, V_DIS_VOLT = 8'h00;
    localparam logic [7:0] M_QSTOP = 8'h86, V_QSTOP = 8'h02;
    localparam logic [7:0] M_DIS_OP = 8'h8F, V_DIS_OP = 8'h07;
    localparam logic [7:0] M_FAULT_RST = 8'h80, V_FAULT_RST = 8'h80;

    function automatic logic cw_match(input logic [CW_W-1:0] cw,
                                      input logic [7:0] mask,
                                      input logic [7:0] value);
        return (cw[7:0] & mask) == value;
    endfunction

    function automatic logic [SW_W-1:0] sw_pattern(input t_drive_state st);
        logic [SW_W-1:0] sw;
        case (st)
            ST_NOT_READY:   sw = 16'h0000;
            ST_DISABLED:    sw = 16'h0040;
            ST_READY:       sw = 16'h0021;
            ST_SWITCHED_ON: sw = 16'h0023;
            ST_ENABLED:     sw = 16'h0027;
            ST_QUICK_STOP:  sw = 16'h0007;
            ST_FAULT_REACT: sw = 16'h000F;
            ST_FAULT:       sw = 16'h0008;
            default:        sw = 16'h0000;
        endcase
        return sw;
    endfunction

endpackage

[src/drive_power_state_machine.sv]
// Top level of the drive power state machine: input register, state, result register.
// The slave stream takes one word per fieldbus cycle: tdata carries the controlword in
// bits 15:0 and the AL status code in bits 23:16. The master stream returns one word
// per input word: the statusword in bits 15:0, the drive state in bits 18:16 and the
// transition code in bits 23:19.
// The configuration channel writes the AL status value that counts as operational;
// it is always ready and should only be written while no word is in flight.
// A word accepted into the input register passes through the step logic into the result
// register and is then presented on the master side.
// While the receiver takes results, throughput is one word per cycle; the single
// state register is updated as a word moves from the input register to the result
// register, so consecutive words see each other's state without a bubble.
// If the receiver stalls, the result register holds and the input register still
// takes one further word; tready then falls until the result is taken.
// Reset clears both registers, puts the drive in not ready to switch on and restores
// the operational code to 8.
`timescale 1ns / 1ps

module drive_power_state_machine import dpsm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [23:0]         i_s_tdata,    // control_word, link_status
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [23:0]         o_m_tdata,    // status_word, drive_state, transition_code
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [LINK_W-1:0]   i_cfg_data
);

    logic               r_in_valid;
    logic [CW_W-1:0]    r_cw;
    logic [LINK_W-1:0]  r_link;
    logic               r_out_valid;
    t_step_result       r_out;
    t_drive_state       r_state;
    logic [LINK_W-1:0]  r_link_op_code;

    logic               w_advance;
    logic               w_in_take;
    t_step_result       w_step;

    assign w_advance   = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || w_advance;
    assign w_in_take   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    dpsm_step u_step (
        .i_state        (r_state),
        .i_control_word (r_cw),
        .i_link_op      (r_link == r_link_op_code),
        .o_result       (w_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_op_code <= LINK_OP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_link_op_code <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_cw   <= i_s_tdata[CW_W-1:0];
            r_link <= i_s_tdata[CW_W+LINK_W-1:CW_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= ST_NOT_READY;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= w_step.drive_state;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_step;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.transition_code, r_out.drive_state, r_out.status_word};

    // The state only moves when a word passes into the result register.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_state))
        else $error("drive state changed without a word advancing");

    // The presented state always matches the state held for the next word.
    a_state_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_out.drive_state == r_state))
        else $error("result state differs from held state");

    // No transition code means the state did not move.
    a_no_trans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_step.transition_code == TR_NONE) |=> $stable(r_state))
        else $error("state moved without a transition code");

    // A full input register with an empty result register must drain at once.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |-> (w_advance && o_s_tready))
        else $error("pipeline stalled with free result register");

endmodule

[src/dpsm_step.sv]
// Transition logic of the drive state machine for one controlword.
`timescale 1ns / 1ps

module dpsm_step import dpsm_pkg::*; (
    input  t_drive_state      i_state,
    input  logic [CW_W-1:0]   i_control_word,
    input  logic              i_link_op,
    output t_step_result      o_result
);

    t_drive_state next;
    t_trans       code;
    logic [SW_W-1:0] sw;

    always_comb begin
        next = i_state;
        code = TR_NONE;
        case (i_state)
            ST_NOT_READY: begin
                if (i_link_op) begin
                    next = ST_DISABLED; code = TR_NRDY_TO_DIS;
                end
            end
            ST_DISABLED: begin
                if (cw_match(i_control_word, M_SHUTDOWN, V_SHUTDOWN) || i_link_op) begin
                    next = ST_READY; code = TR_DIS_TO_RDY;
                end
            end
            ST_READY: begin
                if (cw_match(i_control_word, M_DIS_VOLT, V_DIS_VOLT)) begin
                    next = ST_DISABLED; code = TR_RDY_TO_DIS;
                end else if (cw_match(i_control_word, M_SWITCH_ON, V_SWITCH_ON)) begin
                    if (cw_match(i_control_word, M_ENABLE, V_ENABLE)) begin
                        next = ST_ENABLED; code = TR_RDY_TO_ENA;
                    end else begin
                        next = ST_SWITCHED_ON; code = TR_RDY_TO_SON;
                    end
                end
            end
            ST_SWITCHED_ON: begin
                if (cw_match(i_control_word, M_SHUTDOWN, V_SHUTDOWN)) begin
                    next = ST_READY; code = TR_SON_TO_RDY;
                end else if (cw_match(i_control_word, M_ENABLE, V_ENABLE)) begin
                    next = ST_ENABLED; code = TR_SON_TO_ENA;
                end else if (cw_match(i_control_word, M_DIS_VOLT, V_DIS_VOLT)) begin
                    next = ST_DISABLED; code = TR_SON_TO_DIS;
                end
            end
            ST_ENABLED: begin
                // Losing the operational link drops the drive unless a milder
                // command has already been matched.
                if (cw_match(i_control_word, M_DIS_OP, V_DIS_OP)) begin
                    next = ST_SWITCHED_ON; code = TR_ENA_TO_SON;
                end else if (cw_match(i_control_word, M_SHUTDOWN, V_SHUTDOWN)) begin
                    next = ST_READY; code = TR_ENA_TO_RDY;
                end else if (cw_match(i_control_word, M_DIS_VOLT, V_DIS_VOLT)
                             || !i_link_op) begin
                    next = ST_DISABLED; code = TR_ENA_TO_DIS;
                end else if (cw_match(i_control_word, M_QSTOP, V_QSTOP)) begin
                    next = ST_QUICK_STOP; code = TR_ENA_TO_QSTOP;
                end
            end
            ST_QUICK_STOP: begin
                if (cw_match(i_control_word, M_DIS_VOLT, V_DIS_VOLT)) begin
                    next = ST_DISABLED; code = TR_QSTOP_TO_DIS;
                end
            end
            ST_FAULT_REACT: begin
                next = ST_FAULT; code = TR_FREACT_TO_FAULT;
            end
            default: begin
                // Fault reset acts on the level of bit 7.
                if (cw_match(i_control_word, M_FAULT_RST, V_FAULT_RST)) begin
                    next = ST_DISABLED; code = TR_FAULT_TO_DIS;
                end
            end
        endcase

        sw = sw_pattern(next);
        if (code == TR_RDY_TO_ENA) begin
            sw = sw | sw_pattern(ST_SWITCHED_ON);
        end

        o_result.status_word     = sw;
        o_result.drive_state     = next;
        o_result.transition_code = code;
    end

endmodule

[bench/tb_drive_power_state_machine.sv]
// Self-checking testbench for the drive power state machine: directed paths, then random traffic.
`timescale 1ns / 1ps

module tb_drive_power_state_machine import dpsm_pkg::*; ;

    // Controlword command masks and values, applied to the low byte.
    localparam logic [7:0] MASK_SHUTDOWN  = 8'h87, VAL_SHUTDOWN  = 8'h06;
    localparam logic [7:0] MASK_SWITCH_ON = 8'h87, VAL_SWITCH_ON = 8'h07;
    localparam logic [7:0] MASK_ENABLE_OP = 8'h8F, VAL_ENABLE_OP = 8'h0F;
    localparam logic [7:0] MASK_DISABLE_V = 8'h82, VAL_DISABLE_V = 8'h00;
    localparam logic [7:0] MASK_QSTOP     = 8'h86, VAL_QSTOP     = 8'h02;
    localparam logic [7:0] MASK_DIS_OP    = 8'h8F, VAL_DIS_OP    = 8'h07;
    localparam logic [7:0] MASK_FAULT_RST = 8'h80, VAL_FAULT_RST = 8'h80;

    localparam int IDLE_PERCENT = 19;
    localparam int LINK_UP_PERCENT = 85;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT = 20000;

    typedef enum int {
        CMD_SHUTDOWN,
        CMD_SWITCH_ON,
        CMD_ENABLE_OP,
        CMD_DISABLE_OP,
        CMD_DISABLE_VOLTAGE,
        CMD_QUICK_STOP,
        CMD_FAULT_RESET,
        CMD_ANY
    } t_command;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [23:0]       i_s_tdata = '0;     // control_word, link_status
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [23:0]       o_m_tdata;          // status_word, drive_state, transition_code
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [LINK_W-1:0] i_cfg_data = '0;

    t_step_result      expected_steps[$];
    t_drive_state      tracked_state = ST_NOT_READY;
    logic [LINK_W-1:0] tracked_op_code = LINK_OP_RESET;
    bit                source_idle_on = 1'b1;
    bit                sink_idle_on = 1'b1;
    int                mismatch_count = 0;

    drive_power_state_machine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic command_hit(input logic [CW_W-1:0] cw, input logic [7:0] mask,
                                         input logic [7:0] value);
        return (cw[7:0] & mask) == value;
    endfunction

    function automatic logic [SW_W-1:0] state_status_word(input t_drive_state st);
        logic [SW_W-1:0] sw;
        case (st)
            ST_NOT_READY:   sw = 16'h0000;
            ST_DISABLED:    sw = 16'h0040;
            ST_READY:       sw = 16'h0021;
            ST_SWITCHED_ON: sw = 16'h0023;
            ST_ENABLED:     sw = 16'h0027;
            ST_QUICK_STOP:  sw = 16'h0007;
            ST_FAULT_REACT: sw = 16'h000F;
            default:        sw = 16'h0008;
        endcase
        return sw;
    endfunction

    // One step of the power state machine; commands are tried in priority order per state.
    function automatic t_step_result drive_step(input t_drive_state st,
                                                input logic [CW_W-1:0] cw,
                                                input logic [LINK_W-1:0] link,
                                                input logic [LINK_W-1:0] op_code);
        t_step_result r;
        t_drive_state nxt;
        t_trans       tr;
        logic         link_up;
        link_up = (link == op_code);
        nxt = st;
        tr = TR_NONE;
        case (st)
            ST_NOT_READY: begin
                if (link_up) begin
                    nxt = ST_DISABLED;
                    tr = TR_NRDY_TO_DIS;
                end
            end
            ST_DISABLED: begin
                if (command_hit(cw, MASK_SHUTDOWN, VAL_SHUTDOWN) || link_up) begin
                    nxt = ST_READY;
                    tr = TR_DIS_TO_RDY;
                end
            end
            ST_READY: begin
                if (command_hit(cw, MASK_DISABLE_V, VAL_DISABLE_V)) begin
                    nxt = ST_DISABLED;
                    tr = TR_RDY_TO_DIS;
                end else if (command_hit(cw, MASK_SWITCH_ON, VAL_SWITCH_ON)) begin
                    if (command_hit(cw, MASK_ENABLE_OP, VAL_ENABLE_OP)) begin
                        nxt = ST_ENABLED;
                        tr = TR_RDY_TO_ENA;
                    end else begin
                        nxt = ST_SWITCHED_ON;
                        tr = TR_RDY_TO_SON;
                    end
                end
            end
            ST_SWITCHED_ON: begin
                if (command_hit(cw, MASK_SHUTDOWN, VAL_SHUTDOWN)) begin
                    nxt = ST_READY;
                    tr = TR_SON_TO_RDY;
                end else if (command_hit(cw, MASK_ENABLE_OP, VAL_ENABLE_OP)) begin
                    nxt = ST_ENABLED;
                    tr = TR_SON_TO_ENA;
                end else if (command_hit(cw, MASK_DISABLE_V, VAL_DISABLE_V)) begin
                    nxt = ST_DISABLED;
                    tr = TR_SON_TO_DIS;
                end
            end
            ST_ENABLED: begin
                if (command_hit(cw, MASK_DIS_OP, VAL_DIS_OP)) begin
                    nxt = ST_SWITCHED_ON;
                    tr = TR_ENA_TO_SON;
                end else if (command_hit(cw, MASK_SHUTDOWN, VAL_SHUTDOWN)) begin
                    nxt = ST_READY;
                    tr = TR_ENA_TO_RDY;
                end else if (command_hit(cw, MASK_DISABLE_V, VAL_DISABLE_V) || !link_up) begin
                    nxt = ST_DISABLED;
                    tr = TR_ENA_TO_DIS;
                end else if (command_hit(cw, MASK_QSTOP, VAL_QSTOP)) begin
                    nxt = ST_QUICK_STOP;
                    tr = TR_ENA_TO_QSTOP;
                end
            end
            ST_QUICK_STOP: begin
                // Enable operation is deliberately ignored here.
                if (command_hit(cw, MASK_DISABLE_V, VAL_DISABLE_V)) begin
                    nxt = ST_DISABLED;
                    tr = TR_QSTOP_TO_DIS;
                end
            end
            ST_FAULT_REACT: begin
                nxt = ST_FAULT;
                tr = TR_FREACT_TO_FAULT;
            end
            default: begin
                if (command_hit(cw, MASK_FAULT_RST, VAL_FAULT_RST)) begin
                    nxt = ST_DISABLED;
                    tr = TR_FAULT_TO_DIS;
                end
            end
        endcase
        r.status_word = state_status_word(nxt);
        // The direct switch-on-and-enable path reports both patterns at once.
        if (tr == TR_RDY_TO_ENA) begin
            r.status_word = r.status_word | state_status_word(ST_SWITCHED_ON);
        end
        r.drive_state = nxt;
        r.transition_code = tr;
        return r;
    endfunction

    // Random controlword that satisfies the given command; bits outside the mask stay random.
    function automatic logic [CW_W-1:0] random_controlword(input t_command kind);
        logic [CW_W-1:0] cw;
        logic [7:0]      mask;
        logic [7:0]      value;
        cw = CW_W'($urandom);
        case (kind)
            CMD_SHUTDOWN:        begin mask = MASK_SHUTDOWN;  value = VAL_SHUTDOWN;  end
            CMD_SWITCH_ON:       begin mask = MASK_SWITCH_ON; value = VAL_SWITCH_ON; end
            CMD_ENABLE_OP:       begin mask = MASK_ENABLE_OP; value = VAL_ENABLE_OP; end
            CMD_DISABLE_OP:      begin mask = MASK_DIS_OP;    value = VAL_DIS_OP;    end
            CMD_DISABLE_VOLTAGE: begin mask = MASK_DISABLE_V; value = VAL_DISABLE_V; end
            CMD_QUICK_STOP:      begin mask = MASK_QSTOP;     value = VAL_QSTOP;     end
            CMD_FAULT_RESET:     begin mask = MASK_FAULT_RST; value = VAL_FAULT_RST; end
            default:             begin mask = 8'h00;          value = 8'h00;         end
        endcase
        cw[7:0] = (cw[7:0] & ~mask) | value;
        return cw;
    endfunction

    // Sends one word and records its expected result once it has been accepted.
    task automatic send_word(input logic [CW_W-1:0] cw, input logic [LINK_W-1:0] link);
        t_step_result r;
        while (source_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {link, cw};
        do @(posedge i_clk); while (!o_s_tready);
        r = drive_step(tracked_state, cw, link, tracked_op_code);
        tracked_state = r.drive_state;
        expected_steps.push_back(r);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        i_s_tvalid <= 1'b0;
        while (expected_steps.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_link_op_code(input logic [LINK_W-1:0] code);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= code;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracked_op_code = code;
    endtask

    task automatic check_result(input logic [23:0] word);
        t_step_result want;
        if (expected_steps.size() == 0) begin
            $error("unexpected result word %h", word);
            mismatch_count++;
        end else begin
            want = expected_steps.pop_front();
            if (word[15:0] !== want.status_word) begin
                $error("status_word: expected %h, got %h", want.status_word, word[15:0]);
                mismatch_count++;
            end
            if (word[18:16] !== want.drive_state) begin
                $error("drive_state: expected %0d, got %0d", want.drive_state, word[18:16]);
                mismatch_count++;
            end
            if (word[23:19] !== want.transition_code) begin
                $error("transition_code: expected %0d, got %0d",
                       want.transition_code, word[23:19]);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            check_result(o_m_tdata);
        end
        i_m_tready <= !(sink_idle_on && $urandom_range(99) < IDLE_PERCENT);
    end

    // Link coming up takes the drive out of not ready; a shutdown command then brings it to ready.
    task automatic test_power_up();
        send_word(16'h0000, 8'h00);
        send_word(16'hFFFF, 8'hFF);
        send_word(16'h0000, tracked_op_code);
        send_word(16'hFF87, 8'h00);
        send_word(16'hFF06, 8'h00);
        send_word(16'hFFFF, 8'h00);
    endtask

    // Most operation transitions, including the direct enable; the lost-link word comes while ready.
    task automatic test_operation_paths();
        logic [LINK_W-1:0] up;
        up = tracked_op_code;
        send_word(16'h0000, up);
        send_word(16'h0000, up);
        send_word(16'h0007, up);
        send_word(16'h000F, up);
        send_word(16'h0007, up);
        send_word(16'h0006, up);
        send_word(16'hFF0F, up);
        send_word(16'h0006, up);
        send_word(16'h000F, up);
        send_word(16'h0002, up);
        send_word(16'h000F, up);
        send_word(16'h0000, up);
        send_word(16'h0006, up);
        send_word(16'h000F, 8'hFF);
        send_word(16'h0006, up);
        send_word(16'h0007, up);
        send_word(16'h0000, up);
    endtask

    task automatic test_random_traffic(input logic [LINK_W-1:0] code, input int count,
                                       input bit idling);
        logic [LINK_W-1:0] link;
        write_link_op_code(code);
        source_idle_on = idling;
        sink_idle_on = idling;
        for (int n = 0; n < count; n++) begin
            link = ($urandom_range(99) < LINK_UP_PERCENT) ? tracked_op_code
                                                          : LINK_W'($urandom);
            send_word(random_controlword(t_command'($urandom_range(0, 7))), link);
        end
        source_idle_on = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_up();
        test_operation_paths();
        test_random_traffic(8'h00, 150, 1'b1);
        test_random_traffic(8'hFF, 150, 1'b0);
        test_random_traffic(LINK_W'($urandom), 150, 1'b1);
        test_random_traffic(LINK_OP_RESET, 150, 1'b1);
        drain_results();
        if (expected_steps.size() != 0) begin
            $error("%0d expected results never arrived", expected_steps.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
